@@ sv/nst_pkg.sv @@
`timescale 1ns / 1ps

package nst_pkg;

  localparam int SCORE_W = 31;
  localparam int TIME_W  = 32;
  localparam int RANK_W  = 6;
  localparam int ENTRY_W = SCORE_W + TIME_W;
  localparam int PC_W    = 4;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef logic [PC_W-1:0] pc_t;
  typedef logic [2:0]      cond_t;

  localparam cond_t COND_ALWAYS    = 3'd0;
  localparam cond_t COND_IN_BEAT   = 3'd1;
  localparam cond_t COND_SCAN_DONE = 3'd2;
  localparam cond_t COND_SORT_LAST = 3'd3;
  localparam cond_t COND_OUT_FREE  = 3'd4;
  localparam cond_t COND_EMIT_LAST = 3'd5;

  localparam pc_t ST_IDLE  = 4'd0;
  localparam pc_t ST_MIN   = 4'd1;
  localparam pc_t ST_REPL  = 4'd2;
  localparam pc_t ST_PICK  = 4'd3;
  localparam pc_t ST_PUT   = 4'd4;
  localparam pc_t ST_FLIP  = 4'd5;
  localparam pc_t ST_ERD   = 4'd6;
  localparam pc_t ST_ELD   = 4'd7;
  localparam pc_t ST_ENEXT = 4'd8;

  typedef struct packed {
    logic  wait_in;
    logic  scan_min;
    logic  scan_pick;
    logic  repl;
    logic  put;
    logic  flip;
    logic  emit_rd;
    logic  emit_ld;
    logic  emit_inc;
    cond_t cond;
    pc_t   tgt;
    pc_t   alt;
  } ctl_t;

  function automatic ctl_t ucode(input pc_t pc);
    ctl_t w;
    w = '0;
    unique case (pc)
      ST_IDLE: begin
        w.wait_in = 1'b1;
        w.cond = COND_IN_BEAT;   w.tgt = ST_MIN;   w.alt = ST_IDLE;
      end
      ST_MIN: begin
        w.scan_min = 1'b1;
        w.cond = COND_SCAN_DONE; w.tgt = ST_REPL;  w.alt = ST_MIN;
      end
      ST_REPL: begin
        w.repl = 1'b1;
        w.cond = COND_ALWAYS;    w.tgt = ST_PICK;  w.alt = ST_PICK;
      end
      ST_PICK: begin
        w.scan_pick = 1'b1;
        w.cond = COND_SCAN_DONE; w.tgt = ST_PUT;   w.alt = ST_PICK;
      end
      ST_PUT: begin
        w.put = 1'b1;
        w.cond = COND_SORT_LAST; w.tgt = ST_FLIP;  w.alt = ST_PICK;
      end
      ST_FLIP: begin
        w.flip = 1'b1;
        w.cond = COND_ALWAYS;    w.tgt = ST_ERD;   w.alt = ST_ERD;
      end
      ST_ERD: begin
        w.emit_rd = 1'b1;
        w.cond = COND_ALWAYS;    w.tgt = ST_ELD;   w.alt = ST_ELD;
      end
      ST_ELD: begin
        w.emit_ld = 1'b1;
        w.cond = COND_OUT_FREE;  w.tgt = ST_ENEXT; w.alt = ST_ELD;
      end
      ST_ENEXT: begin
        w.emit_inc = 1'b1;
        w.cond = COND_EMIT_LAST; w.tgt = ST_IDLE;  w.alt = ST_ERD;
      end
      default: begin
        w.cond = COND_ALWAYS;    w.tgt = ST_IDLE;  w.alt = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ sv/top_n_score_table.sv @@
`timescale 1ns / 1ps

// Top-N score table. Each input beat offers a score and a timestamp; the block
// replaces the first lowest entry if the offer is at least that high, re-sorts
// the table into descending score order and then emits all TABLE_ENTRIES
// entries in rank order, one output beat each, flagging the newest nonzero
// timestamp, whether the offer was taken, and the final entry. The selection
// sort dominates the time that one offer takes, as each pick scans the table
// memory at one read per cycle; output stalls add to it. The sequencer runs
// from a small control ROM. The table sits in a two-bank memory; per-entry
// valid bits make unwritten entries read as zero, so no clearing pass follows
// reset. A new offer is taken once the previous table has been handed over,
// while its last result may still be waiting in the output register.
module top_n_score_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nst_pkg::SCORE_W-1:0] in_new_score,
  input  logic [nst_pkg::TIME_W-1:0]  in_now_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nst_pkg::RANK_W-1:0]  out_rank,
  output logic [nst_pkg::SCORE_W-1:0] out_entry_score,
  output logic [nst_pkg::TIME_W-1:0]  out_entry_time,
  output logic                        out_is_most_recent,
  output logic                        out_accepted,
  output logic                        out_last
);

  localparam int IW    = $clog2(TABLE_ENTRIES);
  localparam int JW    = $clog2(TABLE_ENTRIES + 1);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [JW-1:0] J_END  = JW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] I_LAST = IW'(TABLE_ENTRIES - 1);

  nst_pkg::pc_t pc_r, pc_nxt;
  nst_pkg::ctl_t ctl;
  logic          cond_ok;

  logic [nst_pkg::SCORE_W-1:0] offer_r;
  logic [nst_pkg::TIME_W-1:0]  now_r;
  logic [nst_pkg::SCORE_W-1:0] low_r;
  logic [IW-1:0]               low_idx_r;
  logic [nst_pkg::SCORE_W-1:0] best_r;
  logic [nst_pkg::TIME_W-1:0]  btime_r;
  logic [IW-1:0]               pick_r;
  logic [nst_pkg::TIME_W-1:0]  newest_r;
  logic [IW-1:0]               nidx_r;
  logic                        acc_r;
  logic                        bank_r;
  logic [TABLE_ENTRIES-1:0]    taken_r;
  logic [JW-1:0]               j_r;
  logic [IW-1:0]               i_r;
  logic [IW-1:0]               e_r;
  logic                        rd_v_r;
  logic [IW-1:0]               rd_idx_r;

  logic [nst_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [nst_pkg::ENTRY_W-1:0] mem_q_r;
  logic                        rd_ok_r;

  logic                        wen, ren, scanning, replace;
  logic [AW-1:0]               waddr, raddr;
  logic [nst_pkg::ENTRY_W-1:0] wdata;
  logic [nst_pkg::SCORE_W-1:0] rd_score;
  logic [nst_pkg::TIME_W-1:0]  rd_time;

  logic                        out_valid_r;
  logic [nst_pkg::RANK_W-1:0]  out_rank_r;
  logic [nst_pkg::SCORE_W-1:0] out_score_r;
  logic [nst_pkg::TIME_W-1:0]  out_time_r;
  logic                        out_recent_r, out_acc_r, out_last_r;

  assign ctl      = nst_pkg::ucode(pc_r);
  assign in_stall = !ctl.wait_in;
  assign scanning = ctl.scan_min || ctl.scan_pick;
  assign replace  = ctl.repl && (offer_r >= low_r);
  assign rd_score = rd_ok_r ? mem_q_r[nst_pkg::ENTRY_W-1:nst_pkg::TIME_W] : '0;
  assign rd_time  = rd_ok_r ? mem_q_r[nst_pkg::TIME_W-1:0] : '0;

  always_comb begin
    unique case (ctl.cond)
      nst_pkg::COND_ALWAYS:    cond_ok = 1'b1;
      nst_pkg::COND_IN_BEAT:   cond_ok = in_valid;
      nst_pkg::COND_SCAN_DONE: cond_ok = (j_r == J_END);
      nst_pkg::COND_SORT_LAST: cond_ok = (i_r == I_LAST);
      nst_pkg::COND_OUT_FREE:  cond_ok = !out_valid_r || !out_stall;
      nst_pkg::COND_EMIT_LAST: cond_ok = (e_r == I_LAST);
      default:                 cond_ok = 1'b0;
    endcase
    pc_nxt = cond_ok ? ctl.tgt : ctl.alt;
  end

  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (replace) begin
      wen   = 1'b1;
      waddr = {bank_r, low_idx_r};
      wdata = {offer_r, now_r};
    end else if (ctl.put) begin
      wen   = 1'b1;
      waddr = {~bank_r, i_r};
      wdata = {best_r, btime_r};
    end
    ren   = (scanning && (j_r != J_END)) || ctl.emit_rd;
    raddr = ctl.emit_rd ? {bank_r, e_r} : {bank_r, j_r[IW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      mem_q_r <= mem[raddr];
      rd_ok_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= nst_pkg::ST_IDLE;
      vld_r       <= '0;
      bank_r      <= 1'b0;
      taken_r     <= '0;
      j_r         <= '0;
      i_r         <= '0;
      e_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      rd_v_r <= scanning && (j_r != J_END);
      if (wen) begin
        vld_r[waddr] <= 1'b1;
      end
      if (ctl.wait_in && in_valid) begin
        taken_r <= '0;
        i_r     <= '0;
        e_r     <= '0;
      end
      if (scanning) begin
        j_r <= (j_r == J_END) ? '0 : j_r + 1'b1;
      end
      if (ctl.put) begin
        taken_r[pick_r] <= 1'b1;
        i_r <= (i_r == I_LAST) ? '0 : i_r + 1'b1;
      end
      if (ctl.flip) begin
        bank_r <= ~bank_r;
      end
      if (ctl.emit_inc) begin
        e_r <= (e_r == I_LAST) ? '0 : e_r + 1'b1;
      end
      if (ctl.emit_ld && cond_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wait_in && in_valid) begin
      offer_r  <= in_new_score;
      now_r    <= in_now_time;
      newest_r <= '0;
      nidx_r   <= '0;
    end
    if (ctl.scan_min) begin
      if (j_r == '0) begin
        low_r     <= nst_pkg::SCORE_MAX;
        low_idx_r <= '0;
      end else if (rd_v_r && ((rd_idx_r == '0) || (rd_score < low_r))) begin
        low_r     <= rd_score;
        low_idx_r <= rd_idx_r;
      end
    end
    if (ctl.scan_pick) begin
      if (j_r == '0) begin
        best_r <= '0;
        pick_r <= '0;
      end else if (rd_v_r && !taken_r[rd_idx_r] && (rd_score >= best_r)) begin
        best_r  <= rd_score;
        btime_r <= rd_time;
        pick_r  <= rd_idx_r;
      end
    end
    if (ren) begin
      rd_idx_r <= j_r[IW-1:0];
    end
    if (ctl.repl) begin
      acc_r <= replace;
    end
    if (ctl.put && (btime_r > newest_r)) begin
      newest_r <= btime_r;
      nidx_r   <= i_r;
    end
    if (ctl.emit_ld && cond_ok) begin
      out_rank_r   <= nst_pkg::RANK_W'(e_r);
      out_score_r  <= rd_score;
      out_time_r   <= rd_time;
      out_recent_r <= (e_r == nidx_r) && (newest_r != '0);
      out_acc_r    <= acc_r;
      out_last_r   <= (e_r == I_LAST);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rank           = out_rank_r;
  assign out_entry_score    = out_score_r;
  assign out_entry_time     = out_time_r;
  assign out_is_most_recent = out_recent_r;
  assign out_accepted       = out_acc_r;
  assign out_last           = out_last_r;

  a_beat_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (pc_r == nst_pkg::ST_MIN))
    else $error("offer did not start the min scan");

  a_pick_untaken: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.put |-> !taken_r[pick_r])
    else $error("sort picked an entry twice");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (j_r <= J_END) && (scanning || (j_r == '0)))
    else $error("scan index out of range");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int N          = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 150;
  localparam int HOLD_OFF   = 4000;

  typedef logic [nst_pkg::SCORE_W-1:0] score_t;
  typedef logic [nst_pkg::TIME_W-1:0]  stamp_t;
  typedef logic [nst_pkg::RANK_W-1:0]  rank_t;

  localparam stamp_t STAMP_MAX = '1;

  typedef struct packed {
    rank_t  rank;
    score_t score;
    stamp_t stamp;
    logic   recent;
    logic   acc;
    logic   last;
  } entry_t;

  class rank_table_model;
    score_t score_tab[N];
    stamp_t stamp_tab[N];
    entry_t pending[$];
    int     errors;
    int     checked;

    function new();
      for (int i = 0; i < N; i++) begin
        score_tab[i] = '0;
        stamp_tab[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function score_t lowest();
      score_t lo;
      lo = score_tab[0];
      for (int i = 1; i < N; i++) if (score_tab[i] < lo) lo = score_tab[i];
      return lo;
    endfunction

    function stamp_t newest();
      stamp_t hi;
      hi = '0;
      for (int i = 0; i < N; i++) if (stamp_tab[i] > hi) hi = stamp_tab[i];
      return hi;
    endfunction

    function score_t score_at(int idx);
      return score_tab[idx];
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_offer(score_t s, stamp_t t);
      score_t lo;
      int     lo_idx;
      logic   acc;
      score_t s_sorted[N];
      stamp_t t_sorted[N];
      bit     taken[N];
      int     pick;
      score_t best;
      stamp_t hi;
      int     hi_idx;
      entry_t e;
      lo     = score_tab[0];
      lo_idx = 0;
      for (int i = 1; i < N; i++) begin
        if (score_tab[i] < lo) begin
          lo     = score_tab[i];
          lo_idx = i;
        end
      end
      acc = (s >= lo);
      if (acc) begin
        score_tab[lo_idx] = s;
        stamp_tab[lo_idx] = t;
      end
      for (int i = 0; i < N; i++) taken[i] = 1'b0;
      // selection sort, ties go to the highest position
      for (int i = 0; i < N; i++) begin
        pick = 0;
        best = '0;
        for (int j = 0; j < N; j++) begin
          if (!taken[j] && score_tab[j] >= best) begin
            pick = j;
            best = score_tab[j];
          end
        end
        s_sorted[i] = score_tab[pick];
        t_sorted[i] = stamp_tab[pick];
        taken[pick] = 1'b1;
      end
      hi     = '0;
      hi_idx = -1;
      for (int i = 0; i < N; i++) begin
        score_tab[i] = s_sorted[i];
        stamp_tab[i] = t_sorted[i];
        if (t_sorted[i] > hi) begin
          hi     = t_sorted[i];
          hi_idx = i;
        end
      end
      for (int i = 0; i < N; i++) begin
        e.rank   = rank_t'(i);
        e.score  = score_tab[i];
        e.stamp  = stamp_tab[i];
        e.recent = (i == hi_idx);
        e.acc    = acc;
        e.last   = (i == N - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_entry(entry_t got);
      entry_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected beat: rank %0d score %0d", got.rank, got.score);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, actual %0d", want.rank, got.rank);
        errors++;
      end
      if (got.score !== want.score) begin
        $error("entry_score: expected %0d, actual %0d", want.score, got.score);
        errors++;
      end
      if (got.stamp !== want.stamp) begin
        $error("entry_time: expected %0d, actual %0d", want.stamp, got.stamp);
        errors++;
      end
      if (got.recent !== want.recent) begin
        $error("is_most_recent: expected %0b, actual %0b", want.recent, got.recent);
        errors++;
      end
      if (got.acc !== want.acc) begin
        $error("accepted: expected %0b, actual %0b", want.acc, got.acc);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  score_t in_new_score;
  stamp_t in_now_time;
  logic   out_valid;
  logic   out_stall;
  rank_t  out_rank;
  score_t out_entry_score;
  stamp_t out_entry_time;
  logic   out_is_most_recent;
  logic   out_accepted;
  logic   out_last;

  rank_table_model model = new();
  int  idle_cycles;
  bit  hold_done;

  top_n_score_table #(.TABLE_ENTRIES(N)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_new_score       (in_new_score),
    .in_now_time        (in_now_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_rank           (out_rank),
    .out_entry_score    (out_entry_score),
    .out_entry_time     (out_entry_time),
    .out_is_most_recent (out_is_most_recent),
    .out_accepted       (out_accepted),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic offer_beat(input score_t s, input stamp_t t);
    in_valid     <= 1'b1;
    in_new_score <= s;
    in_now_time  <= t;
    do @(posedge clk); while (in_stall);
    model.note_offer(s, t);
  endtask

  task automatic offer_random();
    score_t s;
    stamp_t t;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) s = score_t'($urandom);
    else if (sel < 55) s = model.lowest();
    else if (sel < 65) s = (model.lowest() == 0) ? score_t'(0) : score_t'(model.lowest() - 1);
    else if (sel < 75) s = score_t'($urandom_range(0, 15));
    else if (sel < 85) s = nst_pkg::SCORE_MAX;
    else s = model.score_at($urandom_range(0, N - 1));
    sel = $urandom_range(0, 99);
    if (sel < 70) t = stamp_t'($urandom);
    else if (sel < 78) t = '0;
    else if (sel < 86) t = STAMP_MAX;
    else t = model.newest();
    offer_beat(s, t);
  endtask

  // directed offers, then random bursts
  initial begin
    int sent;
    int burst;
    int gap;
    int sel;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_new_score <= '0;
    in_now_time  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    offer_beat('0, '0);
    offer_beat('0, '0);
    offer_beat(nst_pkg::SCORE_MAX, STAMP_MAX);
    offer_beat(nst_pkg::SCORE_MAX, 32'd5);
    offer_beat(31'd1, 32'd1);
    offer_beat(31'd5, STAMP_MAX);
    for (int i = 0; i < 5; i++) offer_beat(31'd100, 32'd100 + i);
    offer_beat(31'h2AAAAAAA, 32'h55555555);
    offer_beat(31'h55555555, 32'hAAAAAAAA);
    offer_beat(model.lowest(), 32'd7);
    offer_beat(31'd100, '0);
    offer_beat(31'd0, 32'd9);

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 6);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        offer_random();
        sent++;
      end
      sel = $urandom_range(0, 3);
      gap = (sel == 0) ? 0 : (sel == 3) ? $urandom_range(100, 1400) : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (model.outstanding() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (model.errors == 0 && model.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    int len;
    out_stall <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && model.checked >= 70) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 300);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    entry_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.rank   = out_rank;
      got.score  = out_entry_score;
      got.stamp  = out_entry_time;
      got.recent = out_is_most_recent;
      got.acc    = out_accepted;
      got.last   = out_last;
      model.check_entry(got);
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

@@ top_n_score_table.f @@
sv/nst_pkg.sv
sv/top_n_score_table.sv
verif/tb.sv
